### src/p2i_pkg.sv
// shared constants, types and tables for the perifocal to inertial rotation
`default_nettype none

package p2i_pkg;

    // default configuration
    localparam int VECTOR_WIDTH_DEF    = 32;
    localparam int COEFF_FRAC_BITS_DEF = 16;
    localparam int ANGLE_WIDTH_DEF     = 16;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAAN = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INCL = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERI = 2'd2;

    // cordic in q4.30 with 34 bit datapath
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    // arctangent table in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:    r = 32'h20000000;
                5'd1:    r = 32'h12E4051E;
                5'd2:    r = 32'h09FB385B;
                5'd3:    r = 32'h051111D4;
                5'd4:    r = 32'h028B0D43;
                5'd5:    r = 32'h0145D7E1;
                5'd6:    r = 32'h00A2F61E;
                5'd7:    r = 32'h00517C55;
                5'd8:    r = 32'h0028BE53;
                5'd9:    r = 32'h00145F2F;
                5'd10:   r = 32'h000A2F98;
                5'd11:   r = 32'h000517CC;
                5'd12:   r = 32'h00028BE6;
                5'd13:   r = 32'h000145F3;
                5'd14:   r = 32'h0000A2FA;
                5'd15:   r = 32'h0000517D;
                5'd16:   r = 32'h000028BE;
                5'd17:   r = 32'h0000145F;
                5'd18:   r = 32'h00000A30;
                5'd19:   r = 32'h00000518;
                5'd20:   r = 32'h0000028C;
                5'd21:   r = 32'h00000146;
                5'd22:   r = 32'h000000A3;
                5'd23:   r = 32'h00000051;
                5'd24:   r = 32'h00000029;
                5'd25:   r = 32'h00000014;
                5'd26:   r = 32'h0000000A;
                5'd27:   r = 32'h00000005;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

    // matrix build operand sources
    localparam logic [3:0] SRC_SO = 4'd0;
    localparam logic [3:0] SRC_CO = 4'd1;
    localparam logic [3:0] SRC_SI = 4'd2;
    localparam logic [3:0] SRC_CI = 4'd3;
    localparam logic [3:0] SRC_SW = 4'd4;
    localparam logic [3:0] SRC_CW = 4'd5;
    localparam logic [3:0] SRC_T1 = 4'd6;
    localparam logic [3:0] SRC_T2 = 4'd7;
    localparam logic [3:0] SRC_T3 = 4'd8;
    localparam logic [3:0] SRC_T4 = 4'd9;

    // matrix build destinations
    localparam logic [3:0] DST_T1  = 4'd0;
    localparam logic [3:0] DST_T2  = 4'd1;
    localparam logic [3:0] DST_T3  = 4'd2;
    localparam logic [3:0] DST_T4  = 4'd3;
    localparam logic [3:0] DST_R11 = 4'd4;
    localparam logic [3:0] DST_R12 = 4'd5;
    localparam logic [3:0] DST_R13 = 4'd6;
    localparam logic [3:0] DST_R21 = 4'd7;
    localparam logic [3:0] DST_R22 = 4'd8;
    localparam logic [3:0] DST_R23 = 4'd9;
    localparam logic [3:0] DST_R31 = 4'd10;
    localparam logic [3:0] DST_R32 = 4'd11;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dst;
    } mat_op_t;

    localparam int MAT_STEPS = 16;

    // multiply-accumulate program for four products and eight matrix entries
    function automatic mat_op_t mat_op(input logic [3:0] step);
        mat_op_t op;
        begin
            unique case (step)
                4'd0:    op = '{SRC_SO, SRC_SW, 1'b0, 1'b1, 1'b1, DST_T1};
                4'd1:    op = '{SRC_SO, SRC_CW, 1'b0, 1'b1, 1'b1, DST_T2};
                4'd2:    op = '{SRC_CO, SRC_SW, 1'b0, 1'b1, 1'b1, DST_T3};
                4'd3:    op = '{SRC_CO, SRC_CW, 1'b0, 1'b1, 1'b1, DST_T4};
                4'd4:    op = '{SRC_CO, SRC_CW, 1'b0, 1'b1, 1'b0, DST_R11};
                4'd5:    op = '{SRC_T1, SRC_CI, 1'b1, 1'b0, 1'b1, DST_R11};
                4'd6:    op = '{SRC_CO, SRC_SW, 1'b1, 1'b1, 1'b0, DST_R12};
                4'd7:    op = '{SRC_T2, SRC_CI, 1'b1, 1'b0, 1'b1, DST_R12};
                4'd8:    op = '{SRC_SO, SRC_SI, 1'b0, 1'b1, 1'b1, DST_R13};
                4'd9:    op = '{SRC_SO, SRC_CW, 1'b0, 1'b1, 1'b0, DST_R21};
                4'd10:   op = '{SRC_T3, SRC_CI, 1'b0, 1'b0, 1'b1, DST_R21};
                4'd11:   op = '{SRC_SO, SRC_SW, 1'b1, 1'b1, 1'b0, DST_R22};
                4'd12:   op = '{SRC_T4, SRC_CI, 1'b0, 1'b0, 1'b1, DST_R22};
                4'd13:   op = '{SRC_CO, SRC_SI, 1'b1, 1'b1, 1'b1, DST_R23};
                4'd14:   op = '{SRC_SW, SRC_SI, 1'b0, 1'b1, 1'b1, DST_R31};
                default: op = '{SRC_CW, SRC_SI, 1'b0, 1'b1, 1'b1, DST_R32};
            endcase
            return op;
        end
    endfunction

endpackage

`default_nettype wire

### src/p2i_if.sv
// handshake channels: vector items in, rotated items out, configuration writes
`default_nettype none

interface p2i_in_if #(parameter int VW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] pos_p;
    logic signed [VW-1:0] pos_q;
    logic signed [VW-1:0] pos_w;
    logic signed [VW-1:0] vel_p;
    logic signed [VW-1:0] vel_q;
    logic signed [VW-1:0] vel_w;
    modport source (output valid, pos_p, pos_q, pos_w, vel_p, vel_q, vel_w, input ready);
    modport sink   (input valid, pos_p, pos_q, pos_w, vel_p, vel_q, vel_w, output ready);
endinterface

interface p2i_out_if #(parameter int VW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] pos_i;
    logic signed [VW-1:0] pos_j;
    logic signed [VW-1:0] pos_k;
    logic signed [VW-1:0] vel_i;
    logic signed [VW-1:0] vel_j;
    logic signed [VW-1:0] vel_k;
    logic                 saturated_flag;
    modport source (output valid, pos_i, pos_j, pos_k, vel_i, vel_j, vel_k, saturated_flag,
                    input ready);
    modport sink   (input valid, pos_i, pos_j, pos_k, vel_i, vel_j, vel_k, saturated_flag,
                    output ready);
endinterface

interface p2i_cfg_if #(parameter int AW = 16);
    logic                                 valid;
    logic                                 ready;
    logic [p2i_pkg::CFG_INDEX_WIDTH-1:0]  index;
    logic [AW-1:0]                        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/p2i_cordic.sv
// iterative cordic giving sine and cosine coefficients of one angle
`default_nettype none

module p2i_cordic #(
    parameter int AW = p2i_pkg::ANGLE_WIDTH_DEF,
    parameter int F  = p2i_pkg::COEFF_FRAC_BITS_DEF,
    parameter int CW = F + 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [AW-1:0]        angle,
    output logic                      done,
    output logic signed [CW-1:0]      sin_c,
    output logic signed [CW-1:0]      cos_c
);
    localparam int ZW = p2i_pkg::CORDIC_W;

    logic signed [ZW-1:0] x_reg, y_reg, z_reg;
    logic [4:0]           step_reg;
    logic [1:0]           quad_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [31:0]          z32;
    logic [32:0]          qsum;
    logic [2:0]           qraw;
    logic signed [ZW-1:0] z_init;
    logic signed [ZW-1:0] x_sh, y_sh, atan_x;
    logic signed [ZW-1:0] c_raw, s_raw;

    // quadrant split of the angle scaled to 32 bits of a turn
    assign z32    = {angle, {(32 - AW){1'b0}}};
    assign qsum   = {1'b0, z32} + 33'h020000000;
    assign qraw   = qsum[32:30];
    assign z_init = $signed({2'b00, z32}) - $signed({1'b0, qraw, 30'b0});

    assign x_sh   = x_reg >>> step_reg;
    assign y_sh   = y_reg >>> step_reg;
    assign atan_x = $signed({2'b00, p2i_pkg::atan_turn(step_reg)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == 5'(p2i_pkg::CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= p2i_pkg::CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= z_init;
            quad_reg <= qraw[1:0];
        end
        else if (busy_reg)
        begin
            if (!z_reg[ZW-1])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_x;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_x;
            end
        end
    end

    // quadrant applied by swap and negate
    always_comb
    begin
        unique case (quad_reg)
            2'd0:    begin c_raw = x_reg;  s_raw = y_reg;  end
            2'd1:    begin c_raw = -y_reg; s_raw = x_reg;  end
            2'd2:    begin c_raw = -x_reg; s_raw = -y_reg; end
            default: begin c_raw = y_reg;  s_raw = -x_reg; end
        endcase
    end

    function automatic logic signed [CW-1:0] to_coeff(input logic signed [ZW-1:0] v);
        logic signed [ZW-1:0] t;
        logic signed [ZW-1:0] lim;
        begin
            lim = $signed({{(ZW - 1){1'b0}}, 1'b1}) <<< F;
            t   = (v + ($signed({{(ZW - 1){1'b0}}, 1'b1}) <<< (29 - F))) >>> (30 - F);
            if (t > lim)
                t = lim;
            if (t < -lim)
                t = -lim;
            return t[CW-1:0];
        end
    endfunction

    assign done  = done_reg;
    assign sin_c = to_coeff(s_raw);
    assign cos_c = to_coeff(c_raw);

endmodule

`default_nettype wire

### src/p2i_matrix.sv
// builds the rotation matrix from the three angles with a shared multiplier
`default_nettype none

module p2i_matrix #(
    parameter int AW = p2i_pkg::ANGLE_WIDTH_DEF,
    parameter int F  = p2i_pkg::COEFF_FRAC_BITS_DEF,
    parameter int CW = F + 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 recalc,
    input  wire logic [AW-1:0]        raan,
    input  wire logic [AW-1:0]        incl,
    input  wire logic [AW-1:0]        peri,
    output logic                      mat_ready,
    output logic signed [CW-1:0]      m [9]
);
    localparam int PW = 2 * CW;
    localparam int ACCW = PW + 1;

    localparam logic [1:0] S_START = 2'd0;
    localparam logic [1:0] S_WAIT  = 2'd1;
    localparam logic [1:0] S_MAT   = 2'd2;
    localparam logic [1:0] S_RUN   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [3:0] step_reg, step_next;

    logic signed [CW-1:0] so_reg, co_reg, si_reg, ci_reg, sw_reg, cw_reg;
    logic signed [CW-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [CW-1:0] m_reg [9];
    logic signed [ACCW-1:0] acc_reg;

    logic                 cord_start, cord_done;
    logic [AW-1:0]        cord_angle;
    logic signed [CW-1:0] cord_sin, cord_cos;

    p2i_pkg::mat_op_t     op;
    logic signed [CW-1:0] opa, opb;
    logic signed [PW-1:0] prod;
    logic signed [ACCW-1:0] acc_next;
    logic signed [ACCW-1:0] rnd_full;
    logic signed [CW-1:0] rnd_val;

    always_comb
    begin
        unique case (idx_reg)
            p2i_pkg::REG_RAAN: cord_angle = raan;
            p2i_pkg::REG_INCL: cord_angle = incl;
            default:           cord_angle = peri;
        endcase
    end

    assign cord_start = (state_reg == S_START);

    p2i_cordic #(.AW(AW), .F(F), .CW(CW)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .angle (cord_angle),
        .done  (cord_done),
        .sin_c (cord_sin),
        .cos_c (cord_cos)
    );

    function automatic logic signed [CW-1:0] pick(
        input logic [3:0]           sel,
        input logic signed [CW-1:0] so, co, si, ci, sw, cw, t1, t2, t3, t4
    );
        logic signed [CW-1:0] r;
        begin
            unique case (sel)
                p2i_pkg::SRC_SO: r = so;
                p2i_pkg::SRC_CO: r = co;
                p2i_pkg::SRC_SI: r = si;
                p2i_pkg::SRC_CI: r = ci;
                p2i_pkg::SRC_SW: r = sw;
                p2i_pkg::SRC_CW: r = cw;
                p2i_pkg::SRC_T1: r = t1;
                p2i_pkg::SRC_T2: r = t2;
                p2i_pkg::SRC_T3: r = t3;
                default:         r = t4;
            endcase
            return r;
        end
    endfunction

    assign op  = p2i_pkg::mat_op(step_reg);
    assign opa = pick(op.a_sel, so_reg, co_reg, si_reg, ci_reg, sw_reg, cw_reg,
                      t1_reg, t2_reg, t3_reg, t4_reg);
    assign opb = pick(op.b_sel, so_reg, co_reg, si_reg, ci_reg, sw_reg, cw_reg,
                      t1_reg, t2_reg, t3_reg, t4_reg);
    assign prod = opa * opb;

    always_comb
    begin
        acc_next = op.first ? '0 : acc_reg;
        if (op.neg)
            acc_next = acc_next - ACCW'(prod);
        else
            acc_next = acc_next + ACCW'(prod);
    end

    assign rnd_full = (acc_next + ($signed({{(ACCW - 1){1'b0}}, 1'b1}) <<< (F - 1))) >>> F;
    assign rnd_val  = rnd_full[CW-1:0];

    // sequencer: three cordic runs, then the multiply program
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (cord_done)
                begin
                    if (idx_reg == p2i_pkg::REG_PERI)
                    begin
                        state_next = S_MAT;
                        step_next  = '0;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_START;
                    end
                end
            end
            S_MAT:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(p2i_pkg::MAT_STEPS - 1))
                    state_next = S_RUN;
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
        if (recalc)
        begin
            state_next = S_START;
            idx_next   = p2i_pkg::REG_RAAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_START;
            idx_reg   <= p2i_pkg::REG_RAAN;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WAIT && cord_done)
        begin
            unique case (idx_reg)
                p2i_pkg::REG_RAAN: begin so_reg <= cord_sin; co_reg <= cord_cos; end
                p2i_pkg::REG_INCL: begin si_reg <= cord_sin; ci_reg <= cord_cos; end
                default:           begin sw_reg <= cord_sin; cw_reg <= cord_cos; end
            endcase
        end
        if (state_reg == S_MAT)
        begin
            acc_reg <= acc_next;
            if (op.last)
            begin
                unique case (op.dst)
                    p2i_pkg::DST_T1:  t1_reg   <= rnd_val;
                    p2i_pkg::DST_T2:  t2_reg   <= rnd_val;
                    p2i_pkg::DST_T3:  t3_reg   <= rnd_val;
                    p2i_pkg::DST_T4:  t4_reg   <= rnd_val;
                    p2i_pkg::DST_R11: m_reg[0] <= rnd_val;
                    p2i_pkg::DST_R12: m_reg[1] <= rnd_val;
                    p2i_pkg::DST_R13: m_reg[2] <= rnd_val;
                    p2i_pkg::DST_R21: m_reg[3] <= rnd_val;
                    p2i_pkg::DST_R22: m_reg[4] <= rnd_val;
                    p2i_pkg::DST_R23: m_reg[5] <= rnd_val;
                    p2i_pkg::DST_R31: m_reg[6] <= rnd_val;
                    default:          m_reg[7] <= rnd_val;
                endcase
            end
            m_reg[8] <= ci_reg;
        end
    end

    assign mat_ready = (state_reg == S_RUN);
    assign m         = m_reg;

endmodule

`default_nettype wire

### src/p2i_lane.sv
// one output component: three-column dot product, round and saturate
`default_nettype none

module p2i_lane #(
    parameter int VW = p2i_pkg::VECTOR_WIDTH_DEF,
    parameter int F  = p2i_pkg::COEFF_FRAC_BITS_DEF,
    parameter int CW = F + 3
) (
    input  wire logic                 clk,
    input  wire logic                 en1,
    input  wire logic                 en2,
    input  wire logic                 en3,
    input  wire logic signed [CW-1:0] coeff [3],
    input  wire logic signed [VW-1:0] vin [3],
    output logic signed [VW-1:0]      res,
    output logic                      sat
);
    localparam int LW  = VW / 2;
    localparam int HW  = VW - LW;
    localparam int HPW = CW + HW;
    localparam int LPW = CW + LW + 1;
    localparam int TW  = CW + VW + 3;

    localparam logic signed [TW-1:0] MAXV = {{(TW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [TW-1:0] MINV = {{(TW - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

    logic signed [HPW-1:0]   hp_reg [3];
    logic signed [LPW-1:0]   lp_reg [3];
    logic signed [HPW+1:0]   hs_reg;
    logic signed [LPW+1:0]   ls_reg;
    logic signed [TW-1:0]    tot_reg;
    logic signed [TW-1:0]    rounded;

    // split each component into a signed high half and unsigned low half
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int c = 0; c < 3; c++)
            begin
                hp_reg[c] <= coeff[c] * $signed(vin[c][VW-1:LW]);
                lp_reg[c] <= coeff[c] * $signed({1'b0, vin[c][LW-1:0]});
            end
        end
        if (en2)
        begin
            hs_reg <= (HPW+2)'(hp_reg[0]) + (HPW+2)'(hp_reg[1]) + (HPW+2)'(hp_reg[2]);
            ls_reg <= (LPW+2)'(lp_reg[0]) + (LPW+2)'(lp_reg[1]) + (LPW+2)'(lp_reg[2]);
        end
        if (en3)
            tot_reg <= (TW'(hs_reg) <<< LW) + TW'(ls_reg);
    end

    assign rounded = (tot_reg + ($signed({{(TW - 1){1'b0}}, 1'b1}) <<< (F - 1))) >>> F;

    always_comb
    begin
        sat = 1'b1;
        if (rounded > MAXV)
            res = MAXV[VW-1:0];
        else if (rounded < MINV)
            res = MINV[VW-1:0];
        else
        begin
            res = rounded[VW-1:0];
            sat = 1'b0;
        end
    end

endmodule

`default_nettype wire

### src/perifocal_to_inertial_rotation.sv
// top level: perifocal to inertial rotation of a position and velocity pair
//
//  channel   dir  handshake      payload
//  vec_in    in   valid/ready    pos_p pos_q pos_w vel_p vel_q vel_w
//  vec_out   out  valid/ready    pos_i pos_j pos_k vel_i vel_j vel_k saturated_flag
//  cfg       in   valid/ready    index (0 raan, 1 inclination, 2 periapsis), data
//
// one item per cycle once the matrix is built and while vec_out.ready is high; four
// register stages: the three lane stages, then the output register
// every stage has its own ready, so bubbles fill while a result waits at vec_out
// after reset and after each cfg write the matrix is rebuilt: three 28-step cordic
// runs plus a 16-step multiply program on one shared multiplier, during which
// vec_in.ready is low; cfg.ready is always high
// rst_n clears the handshake state and restarts the matrix build
`default_nettype none

module perifocal_to_inertial_rotation #(
    parameter int VECTOR_WIDTH    = p2i_pkg::VECTOR_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = p2i_pkg::COEFF_FRAC_BITS_DEF,
    parameter int ANGLE_WIDTH     = p2i_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    p2i_in_if.sink           vec_in,
    p2i_out_if.source        vec_out,
    p2i_cfg_if.sink          cfg
);
    localparam int VW = VECTOR_WIDTH;
    localparam int F  = COEFF_FRAC_BITS;
    localparam int AW = ANGLE_WIDTH;
    // coefficients stay within about one in magnitude
    localparam int CW = F + 3;

    // angle registers
    logic [AW-1:0] raan_reg, incl_reg, peri_reg;
    logic          cfg_fire;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;

    // an index past the last register changes no angle register but still restarts the matrix build
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raan_reg <= '0;
            incl_reg <= '0;
            peri_reg <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                p2i_pkg::REG_RAAN: raan_reg <= cfg.data;
                p2i_pkg::REG_INCL: incl_reg <= cfg.data;
                p2i_pkg::REG_PERI: peri_reg <= cfg.data;
                default:           ;
            endcase
        end
    end

    // matrix build
    logic                 mat_ready;
    logic signed [CW-1:0] m [9];

    p2i_matrix #(.AW(AW), .F(F), .CW(CW)) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .recalc    (cfg_fire),
        .raan      (raan_reg),
        .incl      (incl_reg),
        .peri      (peri_reg),
        .mat_ready (mat_ready),
        .m         (m)
    );

    // pipeline flow control: lane stages 1..3 then output register
    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic r1, r2, r3, r4;
    logic in_fire;

    assign r4 = !ov_reg || vec_out.ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;

    assign vec_in.ready = mat_ready && r1;
    assign in_fire      = vec_in.valid && vec_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_fire;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                ov_reg <= v3_reg;
        end
    end

    // six lanes: three matrix rows for each of the two vectors
    logic signed [VW-1:0] pos_v [3];
    logic signed [VW-1:0] vel_v [3];
    logic signed [VW-1:0] lane_res [6];
    logic                 lane_sat [6];

    assign pos_v[0] = vec_in.pos_p;
    assign pos_v[1] = vec_in.pos_q;
    assign pos_v[2] = vec_in.pos_w;
    assign vel_v[0] = vec_in.vel_p;
    assign vel_v[1] = vec_in.vel_q;
    assign vel_v[2] = vec_in.vel_w;

    for (genvar g = 0; g < 6; g++)
    begin : g_lane
        logic signed [CW-1:0] row [3];
        logic signed [VW-1:0] vsel [3];
        assign row[0] = m[(g % 3) * 3 + 0];
        assign row[1] = m[(g % 3) * 3 + 1];
        assign row[2] = m[(g % 3) * 3 + 2];

        // first three lanes take position, the rest velocity
        assign vsel[0] = (g < 3) ? pos_v[0] : vel_v[0];
        assign vsel[1] = (g < 3) ? pos_v[1] : vel_v[1];
        assign vsel[2] = (g < 3) ? pos_v[2] : vel_v[2];

        p2i_lane #(.VW(VW), .F(F), .CW(CW)) u_lane (
            .clk   (clk),
            .en1   (r1),
            .en2   (r2),
            .en3   (r3),
            .coeff (row),
            .vin   (vsel),
            .res   (lane_res[g]),
            .sat   (lane_sat[g])
        );
    end

    // merge: collect the six components and fold the clip flags
    logic signed [VW-1:0] out_reg [6];
    logic                 sat_reg;

    always_ff @(posedge clk)
    begin
        if (r4)
        begin
            for (int k = 0; k < 6; k++)
                out_reg[k] <= lane_res[k];
            sat_reg <= lane_sat[0] | lane_sat[1] | lane_sat[2]
                     | lane_sat[3] | lane_sat[4] | lane_sat[5];
        end
    end

    assign vec_out.valid          = ov_reg;
    assign vec_out.pos_i          = out_reg[0];
    assign vec_out.pos_j          = out_reg[1];
    assign vec_out.pos_k          = out_reg[2];
    assign vec_out.vel_i          = out_reg[3];
    assign vec_out.vel_j          = out_reg[4];
    assign vec_out.vel_k          = out_reg[5];
    assign vec_out.saturated_flag = sat_reg;

endmodule

`default_nettype wire
